@@ hdl/mfb_pkg.sv @@
package mfb_pkg;

  localparam logic [7:0]  STX_BYTE = 8'hFE;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_ID    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_ID = 1'd1;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = 2;
  localparam int CQ_CNT_W = 3;

  typedef struct packed {
    logic       first;
    logic       has_data;
    logic       last;
    logic [7:0] msg_id;
    logic [7:0] length;
    logic [7:0] data;
    logic [7:0] seq;
    logic [7:0] sys_id;
    logic [7:0] comp_id;
    logic [7:0] extra;
  } mfb_cmd_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mfb_q_ctl_t;

  typedef struct packed {
    logic full;
    logic rd_valid;
  } mfb_q_sts_t;

  function automatic logic [7:0] extra_lookup(input logic [7:0] id);
    logic [7:0] e;
    case (id)
      8'd0:    e = 8'd50;
      8'd30:   e = 8'd39;
      8'd33:   e = 8'd119;
      8'd39:   e = 8'd178;
      8'd86:   e = 8'd34;
      default: e = 8'd0;
    endcase
    return e;
  endfunction

  function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ acc[7:0];
    t = t ^ {t[3:0], 4'b0};
    return {8'h00, acc[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'b0, t[7:4]};
  endfunction

endpackage

@@ hdl/mavlink_v1_frame_builder_crc.sv @@
// channel | ports                                   | word
// input   | in_push / in_full                       | one payload byte with first/last tags
// result  | out_pop / out_empty                     | one frame byte, frame_end on crc high
// config  | cfg_valid / cfg_ready, cfg_index        | system id (0) or component id (1)
//
// one frame byte leaves per cycle while a command waits and out is empty or popped
// a 4-word command queue lets input run ahead during header and crc bursts
// in_full rises only when that queue is full; cfg_ready is always high
// synchronous active-low reset; output register is empty after reset
module mavlink_v1_frame_builder_crc #(
  parameter int SEED_TABLE_DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_message_id,
  input  logic [7:0]                    in_payload_length,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_has_data,
  input  logic                          in_first_item,
  input  logic                          in_last_item,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [7:0]                    out_out_byte,
  output logic                          out_frame_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import mfb_pkg::*;

  logic       [7:0] sys_id_r, sys_id_nxt;
  logic       [7:0] comp_id_r, comp_id_nxt;
  logic             accept;
  logic             cmd_push;
  mfb_cmd_t         cmd_in;
  mfb_cmd_t         cmd_head;
  mfb_q_ctl_t       q_ctl;
  mfb_q_sts_t       q_sts;
  logic             head_pop;
  logic             out_valid;

  assign cfg_ready = 1'b1;
  assign in_full   = q_sts.full;
  assign accept    = in_push && !q_sts.full;
  assign out_empty = !out_valid;

  always_comb begin
    sys_id_nxt  = sys_id_r;
    comp_id_nxt = comp_id_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYSTEM_ID:    sys_id_nxt  = cfg_data;
        REG_COMPONENT_ID: comp_id_nxt = cfg_data;
        default:          sys_id_nxt  = sys_id_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_id_r  <= 8'd1;
      comp_id_r <= 8'd1;
    end else begin
      sys_id_r  <= sys_id_nxt;
      comp_id_r <= comp_id_nxt;
    end
  end

  mfb_front #(
    .SEED_TABLE_DEPTH(SEED_TABLE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .message_id     (in_message_id),
    .payload_length (in_payload_length),
    .data_byte      (in_data_byte),
    .has_data       (in_has_data),
    .first_item     (in_first_item),
    .last_item      (in_last_item),
    .system_id      (sys_id_r),
    .component_id   (comp_id_r),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  assign q_ctl.wr_en = cmd_push;
  assign q_ctl.rd_en = head_pop;

  mfb_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (q_ctl),
    .wr_data (cmd_in),
    .sts     (q_sts),
    .rd_data (cmd_head)
  );

  mfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_sts.rd_valid),
    .head          (cmd_head),
    .head_pop      (head_pop),
    .out_valid     (out_valid),
    .out_pop       (out_pop),
    .out_byte      (out_out_byte),
    .out_frame_end (out_frame_end)
  );

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("outputs not cleared by reset");

  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.rd_en |-> q_sts.rd_valid)
    else $error("command queue read while empty");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.wr_en |-> !q_sts.full)
    else $error("command queue written while full");

endmodule

@@ hdl/mfb_cmdq.sv @@
module mfb_cmdq (
  input  logic               clk,
  input  logic               rst_n,
  input  mfb_pkg::mfb_q_ctl_t ctl,
  input  mfb_pkg::mfb_cmd_t   wr_data,
  output mfb_pkg::mfb_q_sts_t sts,
  output mfb_pkg::mfb_cmd_t   rd_data
);
  import mfb_pkg::*;

  mfb_cmd_t            mem_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign sts.full     = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign sts.rd_valid = (cnt_r != '0);
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + CQ_PTR_W'(ctl.wr_en);
    rd_ptr_nxt = rd_ptr_r + CQ_PTR_W'(ctl.rd_en);
    cnt_nxt    = cnt_r + CQ_CNT_W'(ctl.wr_en) - CQ_CNT_W'(ctl.rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/mfb_front.sv @@
module mfb_front #(
  parameter int SEED_TABLE_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        message_id,
  input  logic [7:0]        payload_length,
  input  logic [7:0]        data_byte,
  input  logic              has_data,
  input  logic              first_item,
  input  logic              last_item,
  input  logic [7:0]        system_id,
  input  logic [7:0]        component_id,
  output logic              cmd_push,
  output mfb_pkg::mfb_cmd_t cmd
);
  import mfb_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] seq_r, seq_nxt;
  logic [7:0] held_msg_r, held_msg_nxt;
  logic       live;
  logic [7:0] msg_sel;

  assign live     = first_item || in_frame_r;
  assign msg_sel  = first_item ? message_id : held_msg_r;
  assign cmd_push = accept && live && (first_item || has_data || last_item);

  always_comb begin
    cmd.first    = first_item;
    cmd.has_data = has_data;
    cmd.last     = last_item;
    cmd.msg_id   = msg_sel;
    cmd.length   = payload_length;
    cmd.data     = data_byte;
    cmd.seq      = seq_r;
    cmd.sys_id   = system_id;
    cmd.comp_id  = component_id;
    cmd.extra    = (9'(msg_sel) < 9'(SEED_TABLE_DEPTH)) ? extra_lookup(msg_sel) : 8'd0;
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    seq_nxt      = seq_r;
    held_msg_nxt = held_msg_r;
    if (accept && live) begin
      if (first_item) begin
        held_msg_nxt = message_id;
      end
      if (last_item) begin
        in_frame_nxt = 1'b0;
        seq_nxt      = seq_r + 8'd1;
      end else begin
        in_frame_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      seq_r      <= '0;
      held_msg_r <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      seq_r      <= seq_nxt;
      held_msg_r <= held_msg_nxt;
    end
  end

endmodule

@@ hdl/mfb_back.sv @@
module mfb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  mfb_pkg::mfb_cmd_t head,
  output logic              head_pop,
  output logic              out_valid,
  input  logic              out_pop,
  output logic [7:0]        out_byte,
  output logic              out_frame_end
);
  import mfb_pkg::*;

  localparam logic [3:0] ST_STX  = 4'd0;
  localparam logic [3:0] ST_LEN  = 4'd1;
  localparam logic [3:0] ST_SEQ  = 4'd2;
  localparam logic [3:0] ST_SYS  = 4'd3;
  localparam logic [3:0] ST_COMP = 4'd4;
  localparam logic [3:0] ST_MSG  = 4'd5;
  localparam logic [3:0] ST_DATA = 4'd6;
  localparam logic [3:0] ST_CRCL = 4'd7;
  localparam logic [3:0] ST_CRCH = 4'd8;

  logic        started_r, started_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        end_r, end_nxt;

  logic [3:0]  cur;
  logic [3:0]  after;
  logic        done;
  logic        advance;
  logic [7:0]  cur_byte;
  logic [15:0] crc_fin;

  assign advance       = head_valid && (!valid_r || out_pop);
  assign head_pop      = advance && done;
  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_frame_end = end_r;
  assign crc_fin       = crc_feed(crc_r, head.extra);

  always_comb begin
    if (started_r) begin
      cur = step_r;
    end else if (head.first) begin
      cur = ST_STX;
    end else if (head.has_data) begin
      cur = ST_DATA;
    end else begin
      cur = ST_CRCL;
    end
  end

  always_comb begin
    after = ST_STX;
    done  = 1'b0;
    case (cur)
      ST_STX, ST_LEN, ST_SEQ, ST_SYS, ST_COMP: after = cur + 4'd1;
      ST_MSG: begin
        if (head.has_data) begin
          after = ST_DATA;
        end else if (head.last) begin
          after = ST_CRCL;
        end else begin
          done = 1'b1;
        end
      end
      ST_DATA: begin
        if (head.last) begin
          after = ST_CRCL;
        end else begin
          done = 1'b1;
        end
      end
      ST_CRCL: after = ST_CRCH;
      default: done = 1'b1;
    endcase
  end

  always_comb begin
    case (cur)
      ST_STX:  cur_byte = STX_BYTE;
      ST_LEN:  cur_byte = head.length;
      ST_SEQ:  cur_byte = head.seq;
      ST_SYS:  cur_byte = head.sys_id;
      ST_COMP: cur_byte = head.comp_id;
      ST_MSG:  cur_byte = head.msg_id;
      ST_DATA: cur_byte = head.data;
      ST_CRCL: cur_byte = crc_fin[7:0];
      default: cur_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    started_nxt = started_r;
    step_nxt    = step_r;
    crc_nxt     = crc_r;
    valid_nxt   = valid_r && !out_pop;
    byte_nxt    = byte_r;
    end_nxt     = end_r;
    if (advance) begin
      started_nxt = !done;
      step_nxt    = after;
      valid_nxt   = 1'b1;
      byte_nxt    = cur_byte;
      end_nxt     = (cur == ST_CRCH);
      case (cur)
        ST_STX:  crc_nxt = CRC_INIT;
        ST_CRCL: crc_nxt = crc_fin;
        ST_CRCH: crc_nxt = CRC_INIT;
        default: crc_nxt = crc_feed(crc_r, cur_byte);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      step_r    <= ST_STX;
      crc_r     <= CRC_INIT;
      valid_r   <= 1'b0;
    end else begin
      started_r <= started_nxt;
      step_r    <= step_nxt;
      crc_r     <= crc_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
  end

endmodule

@@ tb/testbench.sv @@
module testbench;

  localparam int SEED_DEPTH   = 128;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic [mfb_pkg::CFG_IDX_W-1:0] reg_idx_t;

  typedef struct packed {
    logic [7:0] msg;
    logic [7:0] len;
    logic [7:0] data;
    logic       has;
    logic       first;
    logic       last;
  } word_t;

  class frame_scoreboard;
    logic [7:0]  sys_id;
    logic [7:0]  comp_id;
    logic [7:0]  seq;
    logic [7:0]  held_id;
    logic [15:0] crc;
    bit          in_frame;
    logic [8:0]  expected_bytes[$];
    int          errors;
    int          frames_closed;
    int          bytes_checked;
    int          ignored_words;

    function new();
      sys_id = 8'd1;
      comp_id = 8'd1;
      seq = '0;
      held_id = '0;
      crc = mfb_pkg::CRC_INIT;
      in_frame = 0;
      errors = 0;
      frames_closed = 0;
      bytes_checked = 0;
      ignored_words = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [7:0] val);
      if (idx == mfb_pkg::REG_SYSTEM_ID) sys_id = val;
      else if (idx == mfb_pkg::REG_COMPONENT_ID) comp_id = val;
    endfunction

    function logic [7:0] extra_for(logic [7:0] id);
      logic [7:0] e;
      case (id)
        8'd0:    e = 8'd50;
        8'd30:   e = 8'd39;
        8'd33:   e = 8'd119;
        8'd39:   e = 8'd178;
        8'd86:   e = 8'd34;
        default: e = 8'd0;
      endcase
      if (id >= SEED_DEPTH) e = 8'd0;
      return e;
    endfunction

    // reflected bitwise form of the x.25 crc
    function logic [15:0] crc_after(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      return c;
    endfunction

    function void add_byte(logic [7:0] b, logic fe);
      expected_bytes.push_back({fe, b});
    endfunction

    function void add_crc_byte(logic [7:0] b);
      crc = crc_after(crc, b);
      add_byte(b, 1'b0);
    endfunction

    function void note_word(word_t w);
      if (w.first) begin
        crc = mfb_pkg::CRC_INIT;
        held_id = w.msg;
        in_frame = 1;
        add_byte(mfb_pkg::STX_BYTE, 1'b0);
        add_crc_byte(w.len);
        add_crc_byte(seq);
        add_crc_byte(sys_id);
        add_crc_byte(comp_id);
        add_crc_byte(w.msg);
      end else if (!in_frame) begin
        ignored_words++;
        return;
      end
      if (w.has) add_crc_byte(w.data);
      if (w.last) begin
        crc = crc_after(crc, extra_for(held_id));
        add_byte(crc[7:0], 1'b0);
        add_byte(crc[15:8], 1'b1);
        seq = seq + 8'd1;
        crc = mfb_pkg::CRC_INIT;
        in_frame = 0;
        frames_closed++;
      end
    endfunction

    task log_mismatch(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_byte(logic [7:0] b, logic fe);
      logic [8:0] want;
      if (expected_bytes.size() == 0) begin
        log_mismatch($sformatf("unexpected word %02h frame_end %0b", b, fe));
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (b !== want[7:0])
          log_mismatch($sformatf("out_byte %02h, expected %02h", b, want[7:0]));
        if (fe !== want[8])
          log_mismatch($sformatf("frame_end %0b, expected %0b on byte %02h", fe, want[8], b));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_message_id = '0;
  logic [7:0] in_payload_length = '0;
  logic [7:0] in_data_byte = '0;
  logic       in_has_data = 1'b0;
  logic       in_first_item = 1'b0;
  logic       in_last_item = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_frame_end;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  reg_idx_t   cfg_index = '0;
  logic [7:0] cfg_data = '0;

  frame_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_words = 0;
  int cycle_count = 0;
  logic [7:0] known_ids[5] = '{8'd0, 8'd30, 8'd33, 8'd39, 8'd86};

  mavlink_v1_frame_builder_crc #(
    .SEED_TABLE_DEPTH(SEED_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_message_id    (in_message_id),
    .in_payload_length(in_payload_length),
    .in_data_byte     (in_data_byte),
    .in_has_data      (in_has_data),
    .in_first_item    (in_first_item),
    .in_last_item     (in_last_item),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_out_byte     (out_out_byte),
    .out_frame_end    (out_frame_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full)
        sb.note_word('{in_message_id, in_payload_length, in_data_byte,
                       in_has_data, in_first_item, in_last_item});
      if (out_pop && !out_empty) sb.check_byte(out_out_byte, out_frame_end);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  task automatic send_word(input word_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_message_id <= w.msg;
    in_payload_length <= w.len;
    in_data_byte <= w.data;
    in_has_data <= w.has;
    in_first_item <= w.first;
    in_last_item <= w.last;
    do @(posedge clk); while (in_full);
  endtask

  // fill < 0 gives random payload bytes
  task automatic send_frame(input logic [7:0] msg, input int n, input logic [7:0] len,
                            input bit lead_empty, input bit tail_empty, input bit closed,
                            input int fill);
    word_t w;
    int count;
    count = n + lead_empty + tail_empty;
    if (count == 0) count = 1;
    for (int i = 0; i < count; i++) begin
      w.msg = (i == 0) ? msg : 8'($urandom);
      w.len = (i == 0) ? len : 8'($urandom);
      w.data = (fill < 0) ? 8'($urandom) : 8'(fill);
      w.has = !((lead_empty && i == 0) || (tail_empty && i == count - 1) || n == 0);
      w.first = (i == 0);
      w.last = closed && (i == count - 1);
      send_word(w);
      sent_words++;
    end
  endtask

  // word without first tag; dropped unless a frame is open
  task automatic send_stray();
    word_t w;
    w.msg = 8'($urandom);
    w.len = 8'($urandom);
    w.data = 8'($urandom);
    w.has = 1'($urandom);
    w.first = 1'b0;
    w.last = 1'($urandom);
    send_word(w);
  endtask

  task automatic random_frame();
    int r;
    int n;
    logic [7:0] msg;
    logic [7:0] len;
    bit lead;
    bit tail;
    if ($urandom_range(99) < 6) begin
      send_stray();
      return;
    end
    msg = ($urandom_range(99) < 40) ? known_ids[$urandom_range(4)] : 8'($urandom);
    r = $urandom_range(99);
    if (r < 55) n = $urandom_range(1);
    else if (r < 88) n = $urandom_range(2, 5);
    else n = $urandom_range(6, 16);
    lead = (n > 1) && ($urandom_range(99) < 15);
    tail = (n > 1) && ($urandom_range(99) < 15);
    len = ($urandom_range(99) < 85) ? 8'(n) : 8'($urandom);
    send_frame(msg, n, len, lead, tail, $urandom_range(99) >= 8, -1);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_ids(input logic [7:0] sys, input logic [7:0] comp);
    cfg_valid <= 1'b1;
    cfg_index <= mfb_pkg::REG_SYSTEM_ID;
    cfg_data <= sys;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= mfb_pkg::REG_COMPONENT_ID;
    cfg_data <= comp;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table ids, empty and full-scale payloads, wrong lengths, stray and abandoned frames
    send_frame(8'd0, 0, 8'd0, 0, 0, 1, -1);
    send_frame(8'd30, 1, 8'd1, 0, 0, 1, 255);
    send_frame(8'd33, 2, 8'd2, 0, 0, 1, 0);
    send_frame(8'd39, 1, 8'd1, 1, 1, 1, -1);
    send_frame(8'd86, 3, 8'd255, 0, 0, 1, -1);
    send_frame(8'd255, 1, 8'd0, 0, 0, 1, 255);
    send_stray();
    send_frame(8'd128, 2, 8'd2, 0, 0, 0, -1);
    send_frame(8'd127, 1, 8'd1, 0, 0, 1, -1);
    send_frame(8'd1, 0, 8'd0, 1, 1, 1, -1);
    wait_drained();

    set_ids(8'd0, 8'd255);
    send_idle_pct = 30;
    recv_idle_pct = 50;
    while (sent_words < 160) random_frame();
    wait_drained();

    set_ids(8'd255, 8'd0);
    send_idle_pct = 50;
    recv_idle_pct = 30;
    while (sent_words < 310) random_frame();
    wait_drained();

    set_ids(8'($urandom), 8'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent_words < 460) random_frame();
    wait_drained();

    $display("%0d words in frames, %0d stray words dropped, %0d frames closed",
             sent_words, sb.ignored_words, sb.frames_closed);
    $display("%0d frame bytes checked; table ids, ids at both extremes and random ids",
             sb.bytes_checked);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
hdl/mfb_pkg.sv
hdl/mfb_cmdq.sv
hdl/mfb_front.sv
hdl/mfb_back.sv
hdl/mavlink_v1_frame_builder_crc.sv
tb/testbench.sv
